@@ hdl/telemetry_command_frame_receiver_assert.svh @@
// Assertion macros for the command frame receiver module.
`ifndef TELEMETRY_COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define TELEMETRY_COMMAND_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcfr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcfr assertion failed");

`endif

@@ hdl/tcfr_pkg.sv @@
// Types and constants of the command frame receiver.
package tcfr_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
    localparam logic [7:0] ACK_TAG     = 8'hEF;
    localparam logic [7:0] ACK_LEN     = 8'h02;

    localparam logic [7:0] FN_CAL      = 8'h01;
    localparam logic [7:0] FN_READ     = 8'h02;
    localparam logic [7:0] FN_GAINS    = 8'h10;
    localparam logic [7:0] FN_SAVE_B   = 8'h11;
    localparam logic [7:0] FN_SAVE_C   = 8'h13;
    localparam logic [7:0] FN_GROUP_HI = 8'h15;

    localparam logic [7:0] ARG_ACC     = 8'h01;
    localparam logic [7:0] ARG_GYRO    = 8'h02;
    localparam logic [7:0] ARG_MAG     = 8'h04;
    localparam logic [7:0] ARG_BARO    = 8'h05;
    localparam logic [7:0] ARG_PID     = 8'h01;
    localparam logic [7:0] ARG_VERSION = 8'hA0;

    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_ACC_CAL  = 4'd1;
    localparam logic [3:0] EV_GYRO_CAL = 4'd2;
    localparam logic [3:0] EV_MAG_CAL  = 4'd3;
    localparam logic [3:0] EV_BARO_CAL = 4'd4;
    localparam logic [3:0] EV_PID_READ = 4'd5;
    localparam logic [3:0] EV_VERSION  = 4'd6;
    localparam logic [3:0] EV_GAINS    = 4'd7;
    localparam logic [3:0] EV_GROUP    = 4'd8;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    localparam int HEAD_DEPTH = 6;
    localparam int ACK_BEATS  = 7;
    localparam int BEAT_W     = $clog2(ACK_BEATS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int AckSumInt = 2 * 8'hAA + 8'hEF + 8'h02;
    localparam logic [7:0] ACK_SUM_BASE = AckSumInt[7:0];

    typedef struct packed {
        logic [7:0]  func;
        logic [3:0]  event_code;
        logic        save;
        logic        ack;
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [7:0]  sum;
    } t_frame_rec;

    typedef struct packed {
        logic       valid;
        t_frame_rec rec;
    } t_frame_push;

endpackage

@@ hdl/tcfr_parser.sv @@
// Byte-by-byte frame parser that hands a decoded record out on each good frame.
module tcfr_parser
    import tcfr_pkg::*;
#(
    parameter int LENGTH_LIMIT = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    output t_frame_push o_push
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_FUNC = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SUM  = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [5:0] r_rem, n_rem;
    logic [5:0] r_cnt, n_cnt;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_func, n_func;
    logic [7:0] r_head [HEAD_DEPTH];
    logic [7:0] n_head [HEAD_DEPTH];
    logic       sum_ok;
    t_frame_rec rec;

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_func  = r_func;
        n_head  = r_head;
        sum_ok  = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == HDR_FIRST) begin
                        n_phase = PH_HDR2;
                        n_sum   = i_rx_byte;
                    end
                end
                PH_HDR2: begin
                    if (i_rx_byte == HDR_SECOND) begin
                        n_phase = PH_FUNC;
                        n_sum   = r_sum + i_rx_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_FUNC: begin
                    if (i_rx_byte < FUNC_LIMIT) begin
                        n_phase = PH_LEN;
                        n_func  = i_rx_byte;
                        n_sum   = r_sum + i_rx_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN: begin
                    if ({1'b0, i_rx_byte} < 9'(LENGTH_LIMIT)) begin
                        n_phase = PH_DATA;
                        n_rem   = i_rx_byte[5:0];
                        n_cnt   = '0;
                        n_sum   = r_sum + i_rx_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (r_rem != '0) begin
                        n_rem = r_rem - 6'd1;
                        for (int i = 0; i < HEAD_DEPTH; i++) begin
                            if (r_cnt == 6'(i)) begin
                                n_head[i] = i_rx_byte;
                            end
                        end
                        n_cnt = r_cnt + 6'd1;
                        n_sum = r_sum + i_rx_byte;
                        if (r_rem == 6'd1) begin
                            n_phase = PH_SUM;
                        end
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_SUM: begin
                    n_phase = PH_HUNT;
                    sum_ok  = (r_sum == i_rx_byte);
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        rec            = '0;
        rec.func       = r_func;
        rec.sum        = r_sum;
        rec.event_code = EV_NONE;
        if (r_func == FN_CAL) begin
            case (r_head[0])
                ARG_ACC:  rec.event_code = EV_ACC_CAL;
                ARG_GYRO: rec.event_code = EV_GYRO_CAL;
                ARG_MAG:  rec.event_code = EV_MAG_CAL;
                ARG_BARO: rec.event_code = EV_BARO_CAL;
                default:  rec.event_code = EV_NONE;
            endcase
        end else if (r_func == FN_READ) begin
            case (r_head[0])
                ARG_PID:     rec.event_code = EV_PID_READ;
                ARG_VERSION: rec.event_code = EV_VERSION;
                default:     rec.event_code = EV_NONE;
            endcase
        end else if (r_func == FN_GAINS) begin
            rec.event_code = EV_GAINS;
            rec.save       = 1'b1;
            rec.ack        = 1'b1;
            rec.gain_p     = {r_head[0], r_head[1]};
            rec.gain_i     = {r_head[2], r_head[3]};
            rec.gain_d     = {r_head[4], r_head[5]};
        end else if (r_func >= FN_SAVE_B && r_func <= FN_GROUP_HI) begin
            rec.event_code = EV_GROUP;
            rec.ack        = 1'b1;
            rec.save       = (r_func == FN_SAVE_B) || (r_func == FN_SAVE_C);
        end
    end

    assign o_push.valid = sum_ok;
    assign o_push.rec   = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_func  <= '0;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_func  <= n_func;
            r_head  <= n_head;
        end
    end

endmodule

@@ hdl/telemetry_command_frame_receiver.sv @@
// Command frame receiver: parses received serial bytes into frame events and acknowledges.
//
// Input channel: one received byte per request on i_rx_byte, handshake i_in_valid and
// o_in_ready. The parser takes a byte in the cycle it is offered whenever the two-entry
// frame queue has room, so bytes stream in at one per cycle.
// Output channel: results on the o_* field ports, handshake o_out_valid and i_out_ready.
// A byte that closes a frame with a matching checksum yields one event result, and for
// functions 0x10 to 0x15 seven acknowledge byte results follow it; o_last_of_run marks
// the final result of each run. Other bytes yield nothing.
// Ordering: the record of a frame is written into the frame queue when its checksum byte
// is taken, and its first result is loaded from there into the output register. Results
// leave at one per cycle while i_out_ready is high; an acknowledged frame yields eight.
// Stall: while i_out_ready is low the output register holds its result; frames keep
// parsing into the queue and o_in_ready falls only when the queue holds two frames.
// Reset: synchronous, active low; the parser returns to header hunting, the stored
// payload head bytes and running sum clear, and the queue and output empty.
module telemetry_command_frame_receiver
    import tcfr_pkg::*;
#(
    parameter int LENGTH_LIMIT = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_item_kind,
    output logic [3:0]  o_event_code,
    output logic [7:0]  o_function_code,
    output logic        o_save_request,
    output logic [15:0] o_gain_p_raw,
    output logic [15:0] o_gain_i_raw,
    output logic [15:0] o_gain_d_raw,
    output logic [7:0]  o_ack_byte,
    output logic        o_last_of_run
);

`include "telemetry_command_frame_receiver_assert.svh"

    t_frame_push           push;
    logic                  in_accept;
    t_frame_rec            r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr;
    logic [QPTR_W-1:0]     r_rd_ptr;
    logic [QCNT_W-1:0]     r_count;
    logic [BEAT_W-1:0]     r_beat;
    t_frame_rec            head;
    logic                  load;
    logic                  pop;
    logic                  beat_last;
    logic                  r_out_valid;
    logic                  r_kind, n_kind;
    logic [3:0]            r_event, n_event;
    logic [7:0]            r_func, n_func;
    logic                  r_save, n_save;
    logic [15:0]           r_gp, n_gp;
    logic [15:0]           r_gi, n_gi;
    logic [15:0]           r_gd, n_gd;
    logic [7:0]            r_ack, n_ack;
    logic                  r_last;

    assign o_in_ready = (r_count < QCNT_W'(QUEUE_DEPTH));
    assign in_accept  = i_in_valid && o_in_ready;

    tcfr_parser #(
        .LENGTH_LIMIT(LENGTH_LIMIT)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_rx_byte(i_rx_byte),
        .o_push   (push)
    );

    assign head      = r_queue[r_rd_ptr];
    assign load      = (r_count != '0) && (!r_out_valid || i_out_ready);
    assign beat_last = (r_beat == '0) ? !head.ack : (r_beat == BEAT_W'(ACK_BEATS));
    assign pop       = load && beat_last;

    always_comb begin
        n_kind  = KIND_ACK;
        n_event = EV_NONE;
        n_func  = '0;
        n_save  = 1'b0;
        n_gp    = '0;
        n_gi    = '0;
        n_gd    = '0;
        n_ack   = '0;
        case (r_beat) inside
            3'd0: begin
                n_kind  = KIND_EVENT;
                n_event = head.event_code;
                n_func  = head.func;
                n_save  = head.save;
                n_gp    = head.gain_p;
                n_gi    = head.gain_i;
                n_gd    = head.gain_d;
            end
            3'd1, 3'd2: n_ack = HDR_FIRST;
            3'd3:       n_ack = ACK_TAG;
            3'd4:       n_ack = ACK_LEN;
            3'd5:       n_ack = head.func;
            3'd6:       n_ack = head.sum;
            default:    n_ack = ACK_SUM_BASE + head.func + head.sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_queue[r_wr_ptr] <= push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_beat   <= '0;
        end else begin
            if (push.valid) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push.valid && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push.valid) begin
                r_count <= r_count - QCNT_W'(1);
            end
            if (load) begin
                r_beat <= beat_last ? '0 : r_beat + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_event <= n_event;
            r_func  <= n_func;
            r_save  <= n_save;
            r_gp    <= n_gp;
            r_gi    <= n_gi;
            r_gd    <= n_gd;
            r_ack   <= n_ack;
            r_last  <= beat_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_item_kind     = r_kind;
    assign o_event_code    = r_event;
    assign o_function_code = r_func;
    assign o_save_request  = r_save;
    assign o_gain_p_raw    = r_gp;
    assign o_gain_i_raw    = r_gi;
    assign o_gain_d_raw    = r_gd;
    assign o_ack_byte      = r_ack;
    assign o_last_of_run   = r_last;

    `TCFR_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH))
    `TCFR_ASSERT_IMP(a_beat_has_frame, i_clk, i_rst_n, r_beat != '0, r_count != '0 && head.ack)
    `TCFR_ASSERT_IMP(a_ack_fields_clear, i_clk, i_rst_n, r_out_valid && r_kind == KIND_ACK,
                     r_event == EV_NONE && r_func == '0)
    `TCFR_ASSERT_NXT(a_push_lands, i_clk, i_rst_n, push.valid && !pop, r_count != '0)

endmodule

@@ dv/tb_telemetry_command_frame_receiver.sv @@
// Self-checking testbench for the command frame receiver: byte stream stimulus and result checks.
`timescale 1ns / 1ps

module tb_telemetry_command_frame_receiver;
    import tcfr_pkg::*;

    localparam int FRAME_LEN_LIMIT = 50;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRINT_LIMIT     = 30;

    typedef enum logic [2:0] {
        PH_HUNT, PH_HDR, PH_FUNC, PH_LEN, PH_BODY, PH_CHECK
    } t_parse_phase;

    typedef struct {
        logic        kind;
        logic [3:0]  ev;
        logic [7:0]  fn;
        logic        save;
        logic [15:0] gp;
        logic [15:0] gi;
        logic [15:0] gd;
        logic [7:0]  ack;
        logic        last;
    } t_frame_result;

    localparam int NUM_OPS = 13;
    localparam logic [7:0] OP_FN [NUM_OPS] = '{
        FN_CAL, FN_CAL, FN_CAL, FN_CAL, FN_READ, FN_READ, FN_GAINS,
        FN_SAVE_B, FN_SAVE_B + 8'd1, FN_SAVE_C, FN_SAVE_C + 8'd1, FN_GROUP_HI, FN_READ + 8'd1
    };
    localparam logic [7:0] OP_ARG [NUM_OPS] = '{
        ARG_ACC, ARG_GYRO, ARG_MAG, ARG_BARO, ARG_PID, ARG_VERSION, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_item_kind;
    logic [3:0]  o_event_code;
    logic [7:0]  o_function_code;
    logic        o_save_request;
    logic [15:0] o_gain_p_raw;
    logic [15:0] o_gain_i_raw;
    logic [15:0] o_gain_d_raw;
    logic [7:0]  o_ack_byte;
    logic        o_last_of_run;

    t_parse_phase  phase = PH_HUNT;
    logic [5:0]    bytes_left = '0;
    logic [5:0]    body_count = '0;
    logic [7:0]    frame_sum = '0;
    logic [7:0]    frame_fn = '0;
    logic [7:0]    head_bytes [HEAD_DEPTH] = '{default: 8'h00};
    t_frame_result expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int events_seen = 0;
    int acks_seen = 0;

    telemetry_command_frame_receiver #(
        .LENGTH_LIMIT(FRAME_LEN_LIMIT)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_item_kind    (o_item_kind),
        .o_event_code   (o_event_code),
        .o_function_code(o_function_code),
        .o_save_request (o_save_request),
        .o_gain_p_raw   (o_gain_p_raw),
        .o_gain_i_raw   (o_gain_i_raw),
        .o_gain_d_raw   (o_gain_d_raw),
        .o_ack_byte     (o_ack_byte),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("telemetry_command_frame_receiver test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("Mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    task automatic push_result(input logic kind, input logic [3:0] ev, input logic [7:0] fn,
                               input logic save, input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [7:0] ack, input logic last);
        t_frame_result r;
        r = '{kind, ev, fn, save, gp, gi, gd, ack, last};
        expected_results.push_back(r);
    endtask

    task automatic predict_frame_results();
        logic [3:0]  ev;
        logic        save;
        logic        needs_ack;
        logic [15:0] gp;
        logic [15:0] gi;
        logic [15:0] gd;
        logic [7:0]  ack_bytes [ACK_BEATS];
        logic [7:0]  ack_sum;
        ev = EV_NONE;
        save = 1'b0;
        needs_ack = 1'b0;
        gp = '0;
        gi = '0;
        gd = '0;
        if (frame_fn == FN_CAL) begin
            case (head_bytes[0])
                ARG_ACC:  ev = EV_ACC_CAL;
                ARG_GYRO: ev = EV_GYRO_CAL;
                ARG_MAG:  ev = EV_MAG_CAL;
                ARG_BARO: ev = EV_BARO_CAL;
                default:  ev = EV_NONE;
            endcase
        end else if (frame_fn == FN_READ) begin
            if (head_bytes[0] == ARG_PID) begin
                ev = EV_PID_READ;
            end else if (head_bytes[0] == ARG_VERSION) begin
                ev = EV_VERSION;
            end
        end else if (frame_fn == FN_GAINS) begin
            ev = EV_GAINS;
            save = 1'b1;
            needs_ack = 1'b1;
            gp = {head_bytes[0], head_bytes[1]};
            gi = {head_bytes[2], head_bytes[3]};
            gd = {head_bytes[4], head_bytes[5]};
        end else if (frame_fn >= FN_SAVE_B && frame_fn <= FN_GROUP_HI) begin
            ev = EV_GROUP;
            needs_ack = 1'b1;
            save = (frame_fn == FN_SAVE_B) || (frame_fn == FN_SAVE_C);
        end
        push_result(KIND_EVENT, ev, frame_fn, save, gp, gi, gd, 8'h00, !needs_ack);
        if (needs_ack) begin
            ack_bytes = '{HDR_FIRST, HDR_FIRST, ACK_TAG, ACK_LEN, frame_fn, frame_sum, 8'h00};
            ack_sum = '0;
            for (int k = 0; k < ACK_BEATS - 1; k++) begin
                ack_sum += ack_bytes[k];
            end
            ack_bytes[ACK_BEATS - 1] = ack_sum;
            for (int k = 0; k < ACK_BEATS; k++) begin
                push_result(KIND_ACK, EV_NONE, 8'h00, 1'b0, '0, '0, '0, ack_bytes[k],
                            k == ACK_BEATS - 1);
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] rx);
        if (phase == PH_HUNT && rx == HDR_FIRST) begin
            phase = PH_HDR;
            frame_sum = rx;
        end else if (phase == PH_HDR && rx == HDR_SECOND) begin
            phase = PH_FUNC;
            frame_sum += rx;
        end else if (phase == PH_FUNC && rx < FUNC_LIMIT) begin
            phase = PH_LEN;
            frame_fn = rx;
            frame_sum += rx;
        end else if (phase == PH_LEN && rx < FRAME_LEN_LIMIT) begin
            phase = PH_BODY;
            bytes_left = rx[5:0];
            body_count = '0;
            frame_sum += rx;
        end else if (phase == PH_BODY && bytes_left != 0) begin
            bytes_left--;
            if (body_count < HEAD_DEPTH) begin
                head_bytes[body_count] = rx;
            end
            body_count++;
            frame_sum += rx;
            if (bytes_left == 0) begin
                phase = PH_CHECK;
            end
        end else if (phase == PH_CHECK) begin
            phase = PH_HUNT;
            if (frame_sum == rx) begin
                predict_frame_results();
            end
        end else begin
            phase = PH_HUNT;
        end
    endtask

    task automatic compare_result(input t_frame_result e);
        if (o_item_kind !== e.kind)
            report_mismatch($sformatf("item_kind %0h, want %0h", o_item_kind, e.kind));
        if (o_event_code !== e.ev)
            report_mismatch($sformatf("event_code %0h, want %0h", o_event_code, e.ev));
        if (o_function_code !== e.fn)
            report_mismatch($sformatf("function_code %0h, want %0h", o_function_code, e.fn));
        if (o_save_request !== e.save)
            report_mismatch($sformatf("save_request %0h, want %0h", o_save_request, e.save));
        if (o_gain_p_raw !== e.gp)
            report_mismatch($sformatf("gain_p_raw %0h, want %0h", o_gain_p_raw, e.gp));
        if (o_gain_i_raw !== e.gi)
            report_mismatch($sformatf("gain_i_raw %0h, want %0h", o_gain_i_raw, e.gi));
        if (o_gain_d_raw !== e.gd)
            report_mismatch($sformatf("gain_d_raw %0h, want %0h", o_gain_d_raw, e.gd));
        if (o_ack_byte !== e.ack)
            report_mismatch($sformatf("ack_byte %0h, want %0h", o_ack_byte, e.ack));
        if (o_last_of_run !== e.last)
            report_mismatch($sformatf("last_of_run %0h, want %0h", o_last_of_run, e.last));
    endtask

    // Results are checked before the byte taken at the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no expectation waiting");
                end else begin
                    if (expected_results[0].kind == KIND_ACK) begin
                        acks_seen++;
                    end else begin
                        events_seen++;
                    end
                    compare_result(expected_results.pop_front());
                end
            end
            if (i_in_valid === 1'b1 && o_in_ready === 1'b1) begin
                predict_byte(i_rx_byte);
            end
        end
    end

    task automatic send_byte(input logic [7:0] rx);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] fn, input logic [7:0] len,
                              input logic [7:0] body [$], input bit bad_sum);
        logic [7:0] sum;
        sum = HDR_FIRST + HDR_SECOND + fn + len;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(fn);
        send_byte(len);
        foreach (body[k]) begin
            sum += body[k];
            send_byte(body[k]);
        end
        send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endtask

    task automatic send_random_frame(input logic [7:0] fn, input logic [7:0] head0,
                                     input int min_len, input bit bad_sum);
        logic [7:0] body [$];
        int len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            len = 0;
        end else if (pick < 85) begin
            len = $urandom_range(1, 8);
        end else begin
            len = $urandom_range(9, FRAME_LEN_LIMIT - 1);
        end
        if (len < min_len) begin
            len = min_len;
        end
        for (int k = 0; k < len; k++) begin
            body.push_back(k == 0 ? head0 : 8'($urandom));
        end
        send_frame(fn, 8'(len), body, bad_sum);
    endtask

    task automatic pick_command(output logic [7:0] fn, output logic [7:0] arg);
        int pick;
        pick = $urandom_range(NUM_OPS + 2);
        if (pick < NUM_OPS) begin
            fn = OP_FN[pick];
            arg = (OP_ARG[pick] != 8'h00 && $urandom_range(9) != 0) ? OP_ARG[pick]
                                                                     : 8'($urandom);
        end else begin
            fn = 8'($urandom_range(0, FUNC_LIMIT - 1));
            arg = 8'($urandom);
        end
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_gain_frames();
        send_frame(FN_GAINS, 8'd6, '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01}, 1'b0);
        // A one-byte payload leaves the older gain bytes in place.
        send_frame(FN_GAINS, 8'd1, '{8'h7F}, 1'b0);
    endtask

    task automatic test_malformed_frames();
        logic [7:0] raw [$];
        // The zero-length abort byte is a header byte that must not restart the hunt.
        raw = '{HDR_FIRST, HDR_SECOND, FN_CAL, 8'h00, HDR_FIRST, HDR_SECOND};
        foreach (raw[k]) send_byte(raw[k]);
        send_frame(FN_READ, 8'd1, '{ARG_VERSION}, 1'b1);
        raw = '{HDR_FIRST, HDR_SECOND, FUNC_LIMIT, HDR_FIRST, HDR_FIRST, HDR_SECOND,
                FN_CAL, 8'(FRAME_LEN_LIMIT)};
        foreach (raw[k]) send_byte(raw[k]);
        send_frame(FUNC_LIMIT - 8'd1, 8'd1, '{8'h00}, 1'b0);
    endtask

    task automatic test_each_operation();
        for (int k = 0; k < NUM_OPS; k++) begin
            send_random_frame(OP_FN[k], OP_FN[k] == FN_GAINS ? 8'($urandom) : OP_ARG[k],
                              OP_FN[k] == FN_GAINS ? HEAD_DEPTH : 1, 1'b0);
        end
    endtask

    task automatic test_random_stream(input int target);
        int stop_at;
        int pick;
        logic [7:0] fn;
        logic [7:0] arg;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (pick < 20) begin
                send_byte(HDR_FIRST);
                case ($urandom_range(2))
                    0: send_byte(8'($urandom));
                    1: begin
                        send_byte(HDR_SECOND);
                        send_byte(8'($urandom_range(FUNC_LIMIT, 255)));
                    end
                    default: begin
                        send_byte(HDR_SECOND);
                        send_byte(8'($urandom_range(0, FUNC_LIMIT - 1)));
                        send_byte(8'($urandom_range(FRAME_LEN_LIMIT, 255)));
                    end
                endcase
            end else begin
                pick_command(fn, arg);
                send_random_frame(fn, arg, 0, $urandom_range(99) < 8);
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_rx_byte  <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 79;
        test_gain_frames();
        test_malformed_frames();
        test_each_operation();
        hold_until_drained();
        test_random_stream(30);

        send_idle_pct = 79;
        recv_idle_pct = 7;
        test_random_stream(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(30);

        hold_until_drained();
        $display("Sent %0d bytes; checked %0d frame events and %0d acknowledge bytes.",
                 bytes_sent, events_seen, acks_seen);
        $display("Stall mixes covered: slow sink, slow source, and full-rate streaming.");
        if (error_count == 0) begin
            $display("telemetry_command_frame_receiver test passed");
        end else begin
            $display("telemetry_command_frame_receiver test failed");
        end
        $finish;
    end

endmodule
